FILE: rtl/u16u8_pkg.sv
`default_nettype none

package u16u8_pkg;

   // bytes one request can give: flush of a held unit plus a three-byte unit
   localparam int unsigned MaxBytes   = 6;
   localparam int unsigned CountWidth = $clog2(MaxBytes + 1);
   localparam int unsigned IdxWidth   = $clog2(MaxBytes);

   // job queue between front and back
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned PtrWidth   = $clog2(QueueDepth);
   localparam int unsigned FillWidth  = $clog2(QueueDepth + 1);

   // utf-8 lead and continuation marks
   localparam logic [7:0] LeadTwo   = 8'hC0;
   localparam logic [7:0] LeadThree = 8'hE0;
   localparam logic [7:0] LeadFour  = 8'hF0;
   localparam logic [7:0] ContMark  = 8'h80;

   // surrogate tags in the top six bits of a code unit
   localparam logic [5:0] HighTag = 6'b110110;
   localparam logic [5:0] LowTag  = 6'b110111;

   // byte list of one request, element 0 goes out first
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [CountWidth-1:0]    count;
   } job_type;

   // three-byte form of a 16-bit value
   function automatic logic [2:0][7:0] enc_three(input logic [15:0] u);
      logic [2:0][7:0] b;
      b[0] = LeadThree | {4'd0, u[15:12]};
      b[1] = ContMark  | {2'd0, u[11:6]};
      b[2] = ContMark  | {2'd0, u[5:0]};
      return b;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/utf16_to_utf8_transcoder_unit.sv
// UTF-16 to UTF-8 transcoder. Each request carries one 16-bit code unit and
// yields zero to six UTF-8 bytes on the response channel, one byte per
// response, with rsp_last_of_run set on the final byte of a request. A high
// surrogate is held and gives no bytes until the next unit arrives; a zero
// unit flushes a held surrogate and emits a zero terminator byte. The front
// end classifies a request in the cycle it is taken and pushes its byte list
// into a two-entry job queue; the back end sends one byte per cycle through
// an output register while the receiver takes them. A request produces one
// to three bytes for a plain unit, four for a surrogate pair and up to six
// with a flush. A high surrogate that is only held gives no bytes.
// Requests are taken back to back while the queue has room.
`default_nettype none

module utf16_to_utf8_transcoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_code_unit,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run
);

   logic               push_valid;
   logic               push_ready;
   u16u8_pkg::job_type push_job;
   logic               pop_valid;
   logic               pop_ready;
   u16u8_pkg::job_type pop_job;

   // classify requests and build byte lists
   u16u8_front front_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_unit (req_code_unit),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_job      (push_job)
   );

   // decouple front and back
   u16u8_queue queue_i (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // serialize bytes onto the response channel
   u16u8_back back_i (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (pop_valid),
      .job_ready       (pop_ready),
      .job             (pop_job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

FILE: rtl/u16u8_front.sv
`default_nettype none

module u16u8_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [15:0]       req_code_unit,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output u16u8_pkg::job_type     push_job
);

   logic        held_ff;
   logic        held_in;
   logic [15:0] held_unit_ff;
   logic        accept;
   logic        is_low;
   logic        is_high;
   logic        pair;
   logic [20:0] cp;
   logic [2:0][7:0] held_three;
   logic [2:0][7:0] unit_three;
   logic [2:0][7:0] unit_bytes;
   logic [1:0]      unit_cnt;
   u16u8_pkg::job_type job;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   assign is_low  = req_code_unit[15:10] == u16u8_pkg::LowTag;
   assign is_high = req_code_unit[15:10] == u16u8_pkg::HighTag;
   assign pair    = held_ff && is_low;

   // supplementary code point of a surrogate pair
   assign cp = 21'h010000 + {1'b0, held_unit_ff[9:0], req_code_unit[9:0]};

   assign held_three = u16u8_pkg::enc_three(held_unit_ff);
   assign unit_three = u16u8_pkg::enc_three(req_code_unit);

   // classify the incoming unit on its own
   always_comb begin
      unit_bytes = '0;
      unit_cnt   = 2'd0;
      if (req_code_unit == 16'd0) begin
         unit_cnt = 2'd1;
      end else if (req_code_unit[15:7] == 9'd0) begin
         unit_bytes[0] = req_code_unit[7:0];
         unit_cnt      = 2'd1;
      end else if (req_code_unit[15:11] == 5'd0) begin
         unit_bytes[0] = u16u8_pkg::LeadTwo  | {3'd0, req_code_unit[10:6]};
         unit_bytes[1] = u16u8_pkg::ContMark | {2'd0, req_code_unit[5:0]};
         unit_cnt      = 2'd2;
      end else if (is_high) begin
         unit_cnt = 2'd0;
      end else begin
         unit_bytes = unit_three;
         unit_cnt   = 2'd3;
      end
   end

   // build the byte list; a held unit pairs with a low one or goes first
   always_comb begin
      job = '0;
      if (pair) begin
         job.bytes[0] = u16u8_pkg::LeadFour | {5'd0, cp[20:18]};
         job.bytes[1] = u16u8_pkg::ContMark | {2'd0, cp[17:12]};
         job.bytes[2] = u16u8_pkg::ContMark | {2'd0, cp[11:6]};
         job.bytes[3] = u16u8_pkg::ContMark | {2'd0, cp[5:0]};
         job.count    = u16u8_pkg::CountWidth'(4);
      end else if (held_ff) begin
         job.bytes[0] = held_three[0];
         job.bytes[1] = held_three[1];
         job.bytes[2] = held_three[2];
         job.bytes[3] = unit_bytes[0];
         job.bytes[4] = unit_bytes[1];
         job.bytes[5] = unit_bytes[2];
         job.count    = u16u8_pkg::CountWidth'(unit_cnt) + u16u8_pkg::CountWidth'(3);
      end else begin
         job.bytes[0] = unit_bytes[0];
         job.bytes[1] = unit_bytes[1];
         job.bytes[2] = unit_bytes[2];
         job.count    = u16u8_pkg::CountWidth'(unit_cnt);
      end
   end

   assign push_job   = job;
   assign push_valid = accept && (job.count != '0);

   // held surrogate state
   assign held_in = accept ? (!pair && is_high) : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_high) begin
         held_unit_ff <= req_code_unit;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/u16u8_queue.sv
`default_nettype none

module u16u8_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire u16u8_pkg::job_type  push_job,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output u16u8_pkg::job_type       pop_job
);

   u16u8_pkg::job_type                  mem_ff [u16u8_pkg::QueueDepth];
   logic [u16u8_pkg::PtrWidth-1:0]      wr_ptr_ff;
   logic [u16u8_pkg::PtrWidth-1:0]      wr_ptr_in;
   logic [u16u8_pkg::PtrWidth-1:0]      rd_ptr_ff;
   logic [u16u8_pkg::PtrWidth-1:0]      rd_ptr_in;
   logic [u16u8_pkg::FillWidth-1:0]     fill_ff;
   logic [u16u8_pkg::FillWidth-1:0]     fill_in;
   logic                                do_push;
   logic                                do_pop;

   assign push_ready = fill_ff != u16u8_pkg::FillWidth'(u16u8_pkg::QueueDepth);
   assign pop_valid  = fill_ff != '0;
   assign pop_job    = mem_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == u16u8_pkg::PtrWidth'(u16u8_pkg::QueueDepth - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == u16u8_pkg::PtrWidth'(u16u8_pkg::QueueDepth - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/u16u8_back.sv
`default_nettype none

module u16u8_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                job_valid,
   output logic                     job_ready,
   input  wire u16u8_pkg::job_type  job,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last_of_run
);

   logic [u16u8_pkg::IdxWidth-1:0] idx_ff;
   logic [u16u8_pkg::IdxWidth-1:0] idx_in;
   logic                           valid_ff;
   logic                           valid_in;
   logic [7:0]                     byte_ff;
   logic                           last_ff;
   logic                           load;
   logic                           take;
   logic                           is_last;

   // output register is free when empty or being drained
   assign load    = !valid_ff || rsp_ready;
   assign take    = load && job_valid;
   assign is_last = u16u8_pkg::CountWidth'(idx_ff) == job.count - 1'b1;

   assign job_ready = take && is_last;

   // byte walk through the head job
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (take) begin
         idx_in   = is_last ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= job.bytes[idx_ff];
         last_ff <= is_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

FILE: rtl/u16u8_checker.sv
`default_nettype none

module u16u8_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last_of_run
);

   // response stays offered until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // a terminator byte always closes its request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_byte == 8'd0 |-> rsp_last_of_run)
      else $error("zero byte not marked last");

   // the last byte of a request is never a multi-byte lead
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |-> rsp_out_byte[7:6] != 2'b11)
      else $error("lead byte marked last");

   // nothing offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind utf16_to_utf8_transcoder_unit u16u8_checker checker_i (.*);

`default_nettype wire

FILE: dv/utf16_to_utf8_transcoder_unit_tb.sv
module utf16_to_utf8_transcoder_unit_tb;

   localparam int unsigned IdleLimit   = 2000;
   localparam int unsigned DrainCycles = 20;
   localparam int unsigned RandomUnits = 420;

   // one expected byte on the response channel
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } utf8_byte_type;

   // one stimulus row; typed rows carry their bytes, first byte in the top octet
   typedef struct packed {
      logic [15:0]                      unit;
      logic                             typed;
      logic [u16u8_pkg::CountWidth-1:0] count;
      logic [u16u8_pkg::MaxBytes*8-1:0] bytes;
   } stim_row_type;

   // receiver stall patterns
   typedef enum logic [1:0] {
      RecvFree,
      RecvCoin,
      RecvEveryFourth,
      RecvMostly
   } recv_mode_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_code_unit = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;

   // encoder state mirrored by the testbench
   logic        held_valid = 1'b0;
   logic [15:0] held_unit = '0;

   logic [7:0]    unit_bytes[$];
   utf8_byte_type pending_bytes[$];
   stim_row_type  directed_rows[$];
   utf8_byte_type head_byte;
   int unsigned   error_count = 0;
   int unsigned   idle_cycles = 0;
   int unsigned   burst_left = 0;
   recv_mode_type recv_mode = RecvFree;
   logic [7:0]    recv_phase = '0;

   utf16_to_utf8_transcoder_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_code_unit   (req_code_unit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // three-byte form of a 16-bit value
   task automatic push_three(input logic [15:0] u);
      unit_bytes.push_back({4'b1110, u[15:12]});
      unit_bytes.push_back({2'b10, u[11:6]});
      unit_bytes.push_back({2'b10, u[5:0]});
   endtask

   // utf-8 bytes caused by one code unit, updates the held surrogate
   task automatic encode_unit(input logic [15:0] u);
      logic [20:0] code_point;
      unit_bytes.delete();
      if (held_valid) begin
         held_valid = 1'b0;
         if (u[15:10] == u16u8_pkg::LowTag) begin
            code_point = 21'h10000 + {1'b0, held_unit[9:0], u[9:0]};
            unit_bytes.push_back(u16u8_pkg::LeadFour | {5'd0, code_point[20:18]});
            unit_bytes.push_back(u16u8_pkg::ContMark | {2'd0, code_point[17:12]});
            unit_bytes.push_back(u16u8_pkg::ContMark | {2'd0, code_point[11:6]});
            unit_bytes.push_back(u16u8_pkg::ContMark | {2'd0, code_point[5:0]});
            return;
         end
         push_three(held_unit);
      end
      if (u == 16'd0) begin
         unit_bytes.push_back(8'h00);
      end else if (u[15:7] == '0) begin
         unit_bytes.push_back({1'b0, u[6:0]});
      end else if (u[15:11] == '0) begin
         unit_bytes.push_back(u16u8_pkg::LeadTwo | {3'd0, u[10:6]});
         unit_bytes.push_back(u16u8_pkg::ContMark | {2'd0, u[5:0]});
      end else if (u[15:10] == u16u8_pkg::HighTag) begin
         held_valid = 1'b1;
         held_unit  = u;
      end else begin
         push_three(u);
      end
   endtask

   task automatic add_row(input logic [15:0] unit, input logic typed, input int count,
                          input logic [u16u8_pkg::MaxBytes*8-1:0] bytes);
      stim_row_type row;
      row.unit  = unit;
      row.typed = typed;
      row.count = u16u8_pkg::CountWidth'(count);
      row.bytes = bytes;
      directed_rows.push_back(row);
   endtask

   function automatic stim_row_type plain_row(input logic [15:0] unit);
      stim_row_type row;
      row       = '0;
      row.unit  = unit;
      return row;
   endfunction

   // drive one request in bursts with random gaps, then record its bytes
   task automatic send_row(input stim_row_type row);
      int unsigned gap;
      int n;
      utf8_byte_type eb;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_code_unit <= row.unit;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      encode_unit(row.unit);
      // typed rows replace the computed bytes, state still follows the encoder
      if (row.typed) begin
         unit_bytes.delete();
         for (int i = 0; i < row.count; i++) begin
            unit_bytes.push_back(row.bytes[u16u8_pkg::MaxBytes*8-1-8*i -: 8]);
         end
      end
      n = unit_bytes.size();
      for (int i = 0; i < n; i++) begin
         eb.data = unit_bytes[i];
         eb.last = (i == n - 1);
         pending_bytes.push_back(eb);
      end
   endtask

   // hold off the sender until every expected byte is out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_bytes.size() != 0) @(posedge clock);
   endtask

   // receiver stalls, a new random pattern is picked whenever the phase counter runs out
   always @(posedge clock) begin
      if (recv_phase == 0) begin
         recv_mode  <= recv_mode_type'($urandom_range(0, 3));
         recv_phase <= 8'($urandom_range(20, 120));
      end else begin
         recv_phase <= recv_phase - 8'd1;
      end
      case (recv_mode)
         RecvFree:        rsp_ready <= 1'b1;
         RecvCoin:        rsp_ready <= 1'($urandom_range(0, 1));
         RecvEveryFourth: rsp_ready <= (recv_phase[1:0] == 2'd0);
         default:         rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // response check and idle counter
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_bytes.size() == 0) begin
               $display("%0t: unexpected byte: expected none, actual %h last %b",
                        $time, rsp_out_byte, rsp_last_of_run);
               error_count++;
            end else begin
               head_byte = pending_bytes.pop_front();
               if (rsp_out_byte !== head_byte.data) begin
                  $display("%0t: out_byte: expected %h, actual %h",
                           $time, head_byte.data, rsp_out_byte);
                  error_count++;
               end
               if (rsp_last_of_run !== head_byte.last) begin
                  $display("%0t: last_of_run: expected %b, actual %b",
                           $time, head_byte.last, rsp_last_of_run);
                  error_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (idle_cycles >= IdleLimit) begin
         $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned sent;
      int unsigned pick;
      logic [15:0] u;
      bit          paused;
      sent   = 0;
      paused = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table: extremes, surrogate pairs, flushes, terminators
      add_row(16'h0000, 1'b1, 1, 48'h00_00_00_00_00_00);
      add_row(16'h0001, 1'b1, 1, 48'h01_00_00_00_00_00);
      add_row(16'h007F, 1'b1, 1, 48'h7F_00_00_00_00_00);
      add_row(16'h0080, 1'b1, 2, 48'hC2_80_00_00_00_00);
      add_row(16'h07FF, 1'b1, 2, 48'hDF_BF_00_00_00_00);
      add_row(16'h0800, 1'b1, 3, 48'hE0_A0_80_00_00_00);
      add_row(16'hFFFF, 1'b1, 3, 48'hEF_BF_BF_00_00_00);
      add_row(16'hD800, 1'b1, 0, 48'h0);
      add_row(16'hDC00, 1'b1, 4, 48'hF0_90_80_80_00_00);
      add_row(16'hDBFF, 1'b1, 0, 48'h0);
      add_row(16'hDFFF, 1'b1, 4, 48'hF4_8F_BF_BF_00_00);
      // lone low surrogate
      add_row(16'hDC00, 1'b1, 3, 48'hED_B0_80_00_00_00);
      // held surrogate flushed by an ordinary unit
      add_row(16'hD800, 1'b1, 0, 48'h0);
      add_row(16'h0041, 1'b1, 4, 48'hED_A0_80_41_00_00);
      // held surrogate flushed by the terminator
      add_row(16'hDBFF, 1'b1, 0, 48'h0);
      add_row(16'h0000, 1'b1, 4, 48'hED_AF_BF_00_00_00);
      // high after high: first flushed, second held and paired
      add_row(16'hD83D, 1'b0, 0, 48'h0);
      add_row(16'hD83D, 1'b0, 0, 48'h0);
      add_row(16'hDE00, 1'b0, 0, 48'h0);
      // longest output: flush plus a three-byte unit; then flush plus a two-byte unit
      add_row(16'hD800, 1'b1, 0, 48'h0);
      add_row(16'hFFFF, 1'b1, 6, 48'hED_A0_80_EF_BF_BF);
      add_row(16'hD800, 1'b1, 0, 48'h0);
      add_row(16'h07FF, 1'b1, 5, 48'hED_A0_80_DF_BF_00);
      add_row(16'h5555, 1'b0, 0, 48'h0);
      add_row(16'hAAAA, 1'b0, 0, 48'h0);
      foreach (directed_rows[i]) send_row(directed_rows[i]);
      wait_drained();

      // random part, mostly well-formed text with some broken surrogates
      while (sent < RandomUnits) begin
         if (!paused && sent >= RandomUnits / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            send_row(plain_row(16'($urandom_range(1, 16'h007F))));
            sent++;
         end else if (pick < 40) begin
            send_row(plain_row(16'($urandom_range(16'h0080, 16'h07FF))));
            sent++;
         end else if (pick < 55) begin
            u = 16'($urandom_range(16'h0800, 16'hFFFF));
            if (u[15:11] == 5'b11011) u = u ^ 16'h4000;
            send_row(plain_row(u));
            sent++;
         end else if (pick < 80) begin
            send_row(plain_row(16'($urandom_range(16'hD800, 16'hDBFF))));
            send_row(plain_row(16'($urandom_range(16'hDC00, 16'hDFFF))));
            sent += 2;
         end else if (pick < 85) begin
            send_row(plain_row(16'($urandom_range(16'hD800, 16'hDBFF))));
            sent++;
         end else if (pick < 90) begin
            send_row(plain_row(16'($urandom_range(16'hDC00, 16'hDFFF))));
            sent++;
         end else if (pick < 94) begin
            send_row(plain_row(16'h0000));
            sent++;
         end else begin
            send_row(plain_row(16'($urandom_range(0, 16'hFFFF))));
            sent++;
         end
      end
      // close the string so nothing stays held
      send_row(plain_row(16'h0000));
      req_valid <= 1'b0;

      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
